// File: rtl/tbacc_pkg.sv
// ----------------------------------------------------------------------------
// tbacc_pkg
// Shared types, constants and small decode functions for the two-button
// alarm clock controller.
// ----------------------------------------------------------------------------
package tbacc_pkg;

  localparam int unsigned TimerPeriodDays = 30;  // timer alarm day range
  localparam int unsigned LightSteps      = 11;  // light window range
  localparam int unsigned LastMenuIndex   = 6;

  // event codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_INC     = 2'd1;
  localparam logic [1:0] OP_CONFIRM = 2'd2;

  // menu groups
  localparam logic [1:0] GRP_SHOW  = 2'd0;
  localparam logic [1:0] GRP_SET   = 2'd1;
  localparam logic [1:0] GRP_CLEAR = 2'd2;

  // timer field select
  localparam logic [1:0] TSEL_DAY    = 2'd0;
  localparam logic [1:0] TSEL_HOUR   = 2'd1;
  localparam logic [1:0] TSEL_MINUTE = 2'd2;

  // segment glyphs (bit7 is the decimal point)
  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] SEG_UP_A  = 8'h77;
  localparam logic [7:0] SEG_UP_C  = 8'h39;
  localparam logic [7:0] SEG_LO_D  = 8'h5e;
  localparam logic [7:0] SEG_UP_E  = 8'h79;
  localparam logic [7:0] SEG_UP_G  = 8'h3d;
  localparam logic [7:0] SEG_UP_L  = 8'h38;
  localparam logic [7:0] SEG_UP_N  = 8'h37;
  localparam logic [7:0] SEG_LO_R  = 8'h31;
  localparam logic [7:0] SEG_UP_S  = 8'h6d;
  localparam logic [7:0] SEG_LO_Y  = 8'h6e;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef enum logic [3:0] {
    MODE_SHOWCLOCK  = 4'd0,
    MODE_SHOWLIGHT  = 4'd1,
    MODE_SETCLOCK   = 4'd2,
    MODE_SETTIMER   = 4'd3,
    MODE_SETLIGHT   = 4'd4,
    MODE_CLEARTIMER = 4'd5,
    MODE_CLEARLIGHT = 4'd6,
    MODE_MENU       = 4'd7,
    MODE_ALARM      = 4'd8
  } mode_e;

  typedef struct packed {
    mode_e       cur_mode;
    logic [2:0]  menu_index;
    logic [1:0]  menu_group;
    logic        clock_field_sel;
    logic [1:0]  timer_field_sel;
    logic [5:0]  sec_count;
    logic [5:0]  min_count;
    logic [4:0]  hour_count;
    logic [7:0]  day_count;
    logic [4:0]  alarm_day;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [3:0]  light_level;
    logic [3:0]  light_upper;
    logic [3:0]  light_lower;
    logic        editing_upper;
    logic        timer_alarm_armed;
    logic        light_alarm_armed;
  } state_t;

  // four segment bytes, index 3 is the leftmost digit
  typedef logic [3:0][7:0] seg_t;

  function automatic logic [7:0] seg_font(logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7c;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h67;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // tens digit of a value below 64, by independent threshold compares
  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 6'(k * 10)) t = 4'(k);
    end
    return t;
  endfunction

  // {tens glyph, ones glyph} of a value below 64
  function automatic logic [15:0] two_digits(logic [5:0] v);
    logic [3:0] t;
    logic [5:0] o;
    t = tens_of(v);
    o = v - 6'(6'({2'b00, t}) * 6'd10);
    return {seg_font(t), seg_font(o[3:0])};
  endfunction

  // (sample / 100) mod 10 by threshold compares
  function automatic logic [3:0] light_level_of(logic [9:0] sample);
    logic [3:0] lvl;
    lvl = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (sample >= 10'(k * 100)) lvl = 4'(k);
    end
    if (sample >= 10'd1000) lvl = 4'd0;
    return lvl;
  endfunction

endpackage

// File: rtl/tbacc_core.sv
// ----------------------------------------------------------------------------
// tbacc_core
// Clock, menu and alarm state with the per-event update logic.
// ----------------------------------------------------------------------------
module tbacc_core import tbacc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] op_i,
  input  logic [9:0] sample_i,
  output state_t     state_o
);

  state_t st_q, st_d;

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      unique case (op_i)
        OP_TICK: begin
          st_d.light_level = light_level_of(sample_i);
          if (st_q.cur_mode != MODE_SETCLOCK) begin
            // advance the clock with cascaded wraps
            if (st_q.sec_count == 6'd59) begin
              st_d.sec_count = 6'd0;
              if (st_q.min_count == 6'd59) begin
                st_d.min_count = 6'd0;
                if (st_q.hour_count == 5'd23) begin
                  st_d.hour_count = 5'd0;
                  if (st_q.day_count != 8'hff) st_d.day_count = st_q.day_count + 8'd1;
                end else begin
                  st_d.hour_count = st_q.hour_count + 5'd1;
                end
              end else begin
                st_d.min_count = st_q.min_count + 6'd1;
              end
            end else begin
              st_d.sec_count = st_q.sec_count + 6'd1;
            end
          end
          // timer alarm takes precedence over the light window
          if (st_q.timer_alarm_armed) begin
            if ({3'b000, st_q.alarm_day} == st_d.day_count &&
                st_q.alarm_hour == st_d.hour_count &&
                st_q.alarm_minute == st_d.min_count &&
                st_d.sec_count == 6'd0) begin
              st_d.cur_mode  = MODE_ALARM;
              st_d.day_count = 8'd0;
            end
          end else if (st_q.light_alarm_armed) begin
            if (st_q.light_lower > st_d.light_level ||
                st_q.light_upper < st_d.light_level) begin
              st_d.cur_mode = MODE_ALARM;
            end
          end
        end
        OP_INC: begin
          unique case (st_q.cur_mode)
            MODE_SETCLOCK: begin
              if (!st_q.clock_field_sel) begin
                st_d.hour_count = (st_q.hour_count == 5'd23) ? 5'd0 : st_q.hour_count + 5'd1;
              end else begin
                st_d.min_count = (st_q.min_count == 6'd59) ? 6'd0 : st_q.min_count + 6'd1;
              end
            end
            MODE_SETTIMER: begin
              unique case (st_q.timer_field_sel)
                TSEL_DAY: begin
                  st_d.alarm_day = (st_q.alarm_day == 5'(TimerPeriodDays - 1)) ?
                                   5'd0 : st_q.alarm_day + 5'd1;
                end
                TSEL_HOUR: begin
                  st_d.alarm_hour = (st_q.alarm_hour == 5'd23) ? 5'd0 : st_q.alarm_hour + 5'd1;
                end
                TSEL_MINUTE: begin
                  st_d.alarm_minute = (st_q.alarm_minute == 6'd59) ?
                                      6'd0 : st_q.alarm_minute + 6'd1;
                end
                default: ;
              endcase
            end
            MODE_SHOWLIGHT: st_d.cur_mode = MODE_MENU;
            MODE_SETLIGHT: begin
              if (st_q.editing_upper) begin
                st_d.light_upper = (st_q.light_upper == 4'(LightSteps - 1)) ?
                                   4'd0 : st_q.light_upper + 4'd1;
              end else begin
                st_d.light_lower = (st_q.light_lower == 4'(LightSteps - 1)) ?
                                   4'd0 : st_q.light_lower + 4'd1;
              end
            end
            MODE_MENU: begin
              st_d.menu_index = (st_q.menu_index >= 3'(LastMenuIndex)) ?
                                3'd0 : st_q.menu_index + 3'd1;
              if (st_d.menu_index <= 3'd1)      st_d.menu_group = GRP_SHOW;
              else if (st_d.menu_index <= 3'd4) st_d.menu_group = GRP_SET;
              else                              st_d.menu_group = GRP_CLEAR;
            end
            MODE_ALARM: begin
              st_d.cur_mode          = MODE_MENU;
              st_d.timer_alarm_armed = 1'b0;
              st_d.light_alarm_armed = 1'b0;
            end
            default: ;
          endcase
        end
        OP_CONFIRM: begin
          unique case (st_q.cur_mode)
            MODE_SETCLOCK: begin
              st_d.clock_field_sel = ~st_q.clock_field_sel;
              if (st_q.clock_field_sel) st_d.cur_mode = MODE_MENU;
            end
            MODE_SETTIMER: begin
              unique case (st_q.timer_field_sel)
                TSEL_DAY:  st_d.timer_field_sel = TSEL_HOUR;
                TSEL_HOUR: st_d.timer_field_sel = TSEL_MINUTE;
                TSEL_MINUTE: begin
                  st_d.timer_field_sel   = TSEL_DAY;
                  st_d.cur_mode          = MODE_MENU;
                  st_d.timer_alarm_armed = 1'b1;
                end
                default: ;
              endcase
            end
            MODE_SHOWCLOCK, MODE_SHOWLIGHT, MODE_ALARM: st_d.cur_mode = MODE_MENU;
            MODE_SETLIGHT: begin
              st_d.editing_upper = ~st_q.editing_upper;
              if (st_q.editing_upper) begin
                st_d.cur_mode          = MODE_MENU;
                st_d.light_alarm_armed = 1'b1;
              end
            end
            MODE_CLEARTIMER: begin
              st_d.timer_alarm_armed = 1'b0;
              st_d.cur_mode          = MODE_MENU;
            end
            MODE_CLEARLIGHT: begin
              st_d.light_alarm_armed = 1'b0;
              st_d.cur_mode          = MODE_MENU;
            end
            MODE_MENU: st_d.cur_mode = mode_e'({1'b0, st_q.menu_index});
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= state_t'({MODE_SETCLOCK, {($bits(state_t) - $bits(mode_e)){1'b0}}});
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_d;

endmodule

// File: rtl/tbacc_disp.sv
// ----------------------------------------------------------------------------
// tbacc_disp
// Four-digit seven-segment rendering of the controller state.
// ----------------------------------------------------------------------------
module tbacc_disp import tbacc_pkg::*; (
  input  state_t state_i,
  output seg_t   seg_o
);

  logic [15:0] left_pair, right_pair;

  always_comb begin
    left_pair  = 16'h0000;
    right_pair = 16'h0000;
    seg_o      = '0;
    unique case (state_i.cur_mode)
      MODE_MENU: begin
        unique case (state_i.menu_group)
          GRP_SHOW:  seg_o[3:1] = {SEG_UP_G, SEG_UP_E, SEG_LO_R};
          GRP_SET:   seg_o[3:1] = {SEG_UP_S, SEG_UP_E, SEG_LO_R};
          default:   seg_o[3:1] = {SEG_UP_C, SEG_UP_L, SEG_UP_S};
        endcase
        seg_o[0] = seg_font({1'b0, state_i.menu_index});
      end
      MODE_SHOWCLOCK, MODE_SETCLOCK: begin
        left_pair  = two_digits({1'b0, state_i.hour_count});
        right_pair = two_digits(state_i.min_count);
        seg_o      = {left_pair[15:8], left_pair[7:0] | SEG_POINT, right_pair};
      end
      MODE_SETTIMER: begin
        if (state_i.timer_field_sel == TSEL_DAY) begin
          right_pair = two_digits({1'b0, state_i.alarm_day});
          seg_o      = {SEG_LO_D, SEG_LO_Y, right_pair};
        end else begin
          left_pair  = two_digits({1'b0, state_i.alarm_hour});
          right_pair = two_digits(state_i.alarm_minute);
          seg_o      = {left_pair[15:8], left_pair[7:0] | SEG_POINT, right_pair};
        end
      end
      MODE_SETLIGHT: begin
        left_pair  = two_digits({2'b00, state_i.light_lower});
        right_pair = two_digits({2'b00, state_i.light_upper});
        seg_o      = {left_pair[15:8], left_pair[7:0] | SEG_POINT, right_pair};
      end
      MODE_ALARM: seg_o = {SEG_UP_A, SEG_UP_L, SEG_UP_A, SEG_UP_N};
      MODE_SHOWLIGHT: begin
        right_pair = two_digits({2'b00, state_i.light_level});
        seg_o      = {SEG_UP_L, SEG_LO_R, right_pair};
      end
      default: seg_o = '0;  // clear modes stay blank
    endcase
  end

endmodule

// File: rtl/two_button_alarm_clock_controller_unit.sv
// ----------------------------------------------------------------------------
// two_button_alarm_clock_controller_unit
// Event-driven alarm clock controller with a seven-entry menu, timer alarm
// and light-window alarm, producing one status/display result per event.
// ----------------------------------------------------------------------------
// Each accepted event (tick with light sample, increment press, confirm
// press) yields exactly one result: the event waits in the input register,
// then the state update and display rendering run combinationally into the
// result register. A new event is taken every cycle as long as results are
// drained; while one finished result waits, the input register can still
// take one more event before the input side stalls. No clearing pass after
// reset.
module two_button_alarm_clock_controller_unit import tbacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] light_sample, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] mode_now, [4] alarm_active, [12:5] seg_digit3, [20:13] seg_digit2,
  // [28:21] seg_digit1, [36:29] seg_digit0, [43:37] led_pattern,
  // [45:44] menu_group_out, [50:46] hour_out, [56:51] minute_out,
  // [62:57] second_out, [63] zero
  output logic [63:0] m_axis_tdata
);

  logic        in_valid_q;
  logic [1:0]  in_op_q;
  logic [9:0]  in_sample_q;
  logic        out_valid_q;
  logic [63:0] out_data_q, out_data_d;
  logic        step;
  state_t      st_next;
  seg_t        seg;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q     <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[9:0];
    end
  end

  tbacc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .op_i     (in_op_q),
    .sample_i (in_sample_q),
    .state_o  (st_next)
  );

  tbacc_disp u_disp (
    .state_i (st_next),
    .seg_o   (seg)
  );

  assign out_data_d = {1'b0,
                       st_next.sec_count,
                       st_next.min_count,
                       st_next.hour_count,
                       st_next.menu_group,
                       7'(7'd1 << st_next.menu_index),
                       seg[0], seg[1], seg[2], seg[3],
                       st_next.cur_mode == MODE_ALARM,
                       st_next.cur_mode};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // buzzer flag tracks the alarm mode code
  a_alarm_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[4] == (out_data_q[3:0] == MODE_ALARM)))
    else $error("alarm_active disagrees with mode_now");

  // every processed event leaves a result behind
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed event produced no result");

  // reported time stays within its wrap ranges
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[50:46] <= 5'd23 && out_data_q[56:51] <= 6'd59 &&
                     out_data_q[62:57] <= 6'd59))
    else $error("clock field out of range");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-button alarm clock controller. Events go in
// on the slave stream with random gaps, a local model of the clock, menu and
// alarms predicts each status word, and every transfer on the master stream
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tbacc_pkg::*;

  localparam logic [1:0]  OP_SPARE     = 2'd3;  // unused event code
  localparam int unsigned RandomEvents = 500;

  // status word, last field in the lowest bits
  typedef struct packed {
    logic       pad;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [1:0] grp;
    logic [6:0] leds;
    logic [7:0] seg0;
    logic [7:0] seg1;
    logic [7:0] seg2;
    logic [7:0] seg3;
    logic       alarm;
    logic [3:0] mode;
  } status_t;

  typedef struct {
    mode_e      mode;
    logic [2:0] menu_idx;
    logic [1:0] grp;
    logic       clk_sel;
    logic [1:0] tmr_sel;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [7:0] day;
    logic [4:0] a_day;
    logic [4:0] a_hour;
    logic [5:0] a_min;
    logic [3:0] level;
    logic [3:0] upper;
    logic [3:0] lower;
    logic       edit_upper;
    logic       tmr_armed;
    logic       lt_armed;
  } clock_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [9:0] light_sample, rest zero
  logic [1:0]  s_axis_tuser = '0;  // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [3:0] mode_now, [4] alarm_active, [12:5] seg_digit3, [20:13] seg_digit2,
  // [28:21] seg_digit1, [36:29] seg_digit0, [43:37] led_pattern,
  // [45:44] menu_group_out, [50:46] hour_out, [56:51] minute_out,
  // [62:57] second_out, [63] zero
  logic [63:0] m_axis_tdata;

  clock_state_t ctl;
  status_t      pending_status[$];
  int unsigned  errors = 0;
  int unsigned  events_sent = 0;
  bit           steady = 1'b0;  // no idling on either side while set

  two_button_alarm_clock_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [9:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 10'd0;
    if (r < 20) return 10'd1023;
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [7:0] glyph(int unsigned d);
    case (d % 10)
      0: return 8'h3f;
      1: return 8'h06;
      2: return 8'h5b;
      3: return 8'h4f;
      4: return 8'h66;
      5: return 8'h6d;
      6: return 8'h7c;
      7: return 8'h07;
      8: return 8'h7f;
      default: return 8'h67;
    endcase
  endfunction

  // Advance the local clock model by one event and return the status it shows.
  function automatic status_t apply_event(logic [1:0] op, logic [9:0] sample);
    status_t st;
    logic [3:0][7:0] seg;
    int unsigned lft, rgt;
    if (op == OP_TICK) begin
      ctl.level = 4'((int'(sample) / 100) % 10);
      if (ctl.mode != MODE_SETCLOCK) begin
        if (ctl.sec != 6'd59) ctl.sec++;
        else begin
          ctl.sec = 0;
          if (ctl.min != 6'd59) ctl.min++;
          else begin
            ctl.min = 0;
            if (ctl.hour != 5'd23) ctl.hour++;
            else begin
              ctl.hour = 0;
              if (ctl.day != 8'd255) ctl.day++;
            end
          end
        end
      end
      if (ctl.tmr_armed) begin
        if ({3'b000, ctl.a_day} == ctl.day && ctl.a_hour == ctl.hour &&
            ctl.a_min == ctl.min && ctl.sec == 0) begin
          ctl.mode = MODE_ALARM;
          ctl.day  = 0;
        end
      end else if (ctl.lt_armed) begin
        if (ctl.lower > ctl.level || ctl.upper < ctl.level) ctl.mode = MODE_ALARM;
      end
    end else if (op == OP_INC) begin
      case (ctl.mode)
        MODE_SETCLOCK: begin
          if (!ctl.clk_sel) ctl.hour = 5'((ctl.hour + 1) % 24);
          else ctl.min = 6'((ctl.min + 1) % 60);
        end
        MODE_SETTIMER: begin
          if (ctl.tmr_sel == TSEL_DAY) ctl.a_day = 5'((ctl.a_day + 1) % TimerPeriodDays);
          else if (ctl.tmr_sel == TSEL_HOUR) ctl.a_hour = 5'((ctl.a_hour + 1) % 24);
          else if (ctl.tmr_sel == TSEL_MINUTE) ctl.a_min = 6'((ctl.a_min + 1) % 60);
        end
        MODE_SHOWLIGHT: ctl.mode = MODE_MENU;
        MODE_SETLIGHT: begin
          if (ctl.edit_upper) ctl.upper = 4'((ctl.upper + 1) % LightSteps);
          else ctl.lower = 4'((ctl.lower + 1) % LightSteps);
        end
        MODE_MENU: begin
          if (ctl.menu_idx >= 3'(LastMenuIndex)) ctl.menu_idx = 0;
          else ctl.menu_idx++;
          if (ctl.menu_idx <= 1) ctl.grp = GRP_SHOW;
          else if (ctl.menu_idx <= 4) ctl.grp = GRP_SET;
          else ctl.grp = GRP_CLEAR;
        end
        MODE_ALARM: begin
          ctl.mode      = MODE_MENU;
          ctl.tmr_armed = 1'b0;
          ctl.lt_armed  = 1'b0;
        end
        default: ;
      endcase
    end else if (op == OP_CONFIRM) begin
      case (ctl.mode)
        MODE_SETCLOCK: begin
          if (!ctl.clk_sel) ctl.clk_sel = 1'b1;
          else begin
            ctl.clk_sel = 1'b0;
            ctl.mode    = MODE_MENU;
          end
        end
        MODE_SETTIMER: begin
          if (ctl.tmr_sel == TSEL_DAY) ctl.tmr_sel = TSEL_HOUR;
          else if (ctl.tmr_sel == TSEL_HOUR) ctl.tmr_sel = TSEL_MINUTE;
          else begin
            ctl.tmr_sel   = TSEL_DAY;
            ctl.mode      = MODE_MENU;
            ctl.tmr_armed = 1'b1;
          end
        end
        MODE_SHOWCLOCK, MODE_SHOWLIGHT, MODE_ALARM: ctl.mode = MODE_MENU;
        MODE_SETLIGHT: begin
          if (!ctl.edit_upper) ctl.edit_upper = 1'b1;
          else begin
            ctl.edit_upper = 1'b0;
            ctl.mode       = MODE_MENU;
            ctl.lt_armed   = 1'b1;
          end
        end
        MODE_CLEARTIMER: begin
          ctl.tmr_armed = 1'b0;
          ctl.mode      = MODE_MENU;
        end
        MODE_CLEARLIGHT: begin
          ctl.lt_armed = 1'b0;
          ctl.mode     = MODE_MENU;
        end
        MODE_MENU: ctl.mode = mode_e'({1'b0, ctl.menu_idx});
        default: ;
      endcase
    end

    seg = {4{SEG_BLANK}};
    lft = 0;
    rgt = 0;
    case (ctl.mode)
      MODE_MENU: begin
        if (ctl.grp == GRP_SHOW) seg[3:1] = {SEG_UP_G, SEG_UP_E, SEG_LO_R};
        else if (ctl.grp == GRP_SET) seg[3:1] = {SEG_UP_S, SEG_UP_E, SEG_LO_R};
        else seg[3:1] = {SEG_UP_C, SEG_UP_L, SEG_UP_S};
        seg[0] = glyph(ctl.menu_idx);
      end
      MODE_SHOWCLOCK, MODE_SETCLOCK: begin
        lft = ctl.hour;
        rgt = ctl.min;
      end
      MODE_SETTIMER: begin
        if (ctl.tmr_sel != TSEL_DAY) begin
          lft = ctl.a_hour;
          rgt = ctl.a_min;
        end
      end
      MODE_SETLIGHT: begin
        lft = ctl.lower;
        rgt = ctl.upper;
      end
      MODE_ALARM: seg = {SEG_UP_A, SEG_UP_L, SEG_UP_A, SEG_UP_N};
      MODE_SHOWLIGHT:
        seg = {SEG_UP_L, SEG_LO_R, glyph(ctl.level / 10), glyph(ctl.level)};
      default: ;
    endcase
    // point-separated pairs for the numeric screens
    if (ctl.mode inside {MODE_SHOWCLOCK, MODE_SETCLOCK, MODE_SETLIGHT} ||
        (ctl.mode == MODE_SETTIMER && ctl.tmr_sel != TSEL_DAY))
      seg = {glyph(lft / 10), glyph(lft) | SEG_POINT, glyph(rgt / 10), glyph(rgt)};
    else if (ctl.mode == MODE_SETTIMER)
      seg = {SEG_LO_D, SEG_LO_Y, glyph(ctl.a_day / 10), glyph(ctl.a_day)};

    st.pad    = 1'b0;
    st.second = ctl.sec;
    st.minute = ctl.min;
    st.hour   = ctl.hour;
    st.grp    = ctl.grp;
    st.leds   = 7'(8'd1 << ctl.menu_idx);
    st.seg0   = seg[0];
    st.seg1   = seg[1];
    st.seg2   = seg[2];
    st.seg3   = seg[3];
    st.alarm  = (ctl.mode == MODE_ALARM);
    st.mode   = ctl.mode;
    return st;
  endfunction

  // Send one event; on acceptance, predict its status and queue it.
  task automatic send_event(logic [1:0] op, logic [9:0] sample);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, sample};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_status.push_back(apply_event(op, sample));
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic inc_times(int unsigned n);
    repeat (n) send_event(OP_INC, rand_sample());
  endtask

  task automatic tick_run(int unsigned n);
    repeat (n) send_event(OP_TICK, rand_sample());
  endtask

  // Walk back to the menu, move to an entry and open it.
  task automatic enter_mode(int unsigned idx);
    while (ctl.mode != MODE_MENU) send_event(OP_CONFIRM, rand_sample());
    while (ctl.menu_idx != 3'(idx)) send_event(OP_INC, rand_sample());
    send_event(OP_CONFIRM, rand_sample());
  endtask

  task automatic leave_alarm();
    if (ctl.mode == MODE_ALARM) begin
      if ($urandom_range(0, 1)) tick_run($urandom_range(1, 3));
      send_event($urandom_range(0, 1) ? OP_INC : OP_CONFIRM, rand_sample());
    end
  endtask

  // ---------------------------------------------------------------- tests ---

  task automatic test_unused_op_at_reset();
    send_event(OP_SPARE, 10'd1023);
    send_event(OP_TICK, 10'd1023);  // clock stands still in clock-set mode
  endtask

  task automatic test_clock_set_entry();
    send_event(OP_INC, 10'd0);
    send_event(OP_CONFIRM, 10'd0);
    send_event(OP_INC, 10'd1023);
    send_event(OP_CONFIRM, 10'd0);
  endtask

  task automatic test_show_modes();
    send_event(OP_CONFIRM, 10'd0);      // open show clock
    send_event(OP_TICK, 10'd1023);
    send_event(OP_INC, 10'd0);          // no action here
    send_event(OP_CONFIRM, 10'd0);
    send_event(OP_INC, 10'd0);
    send_event(OP_CONFIRM, 10'd0);      // open show light
    send_event(OP_TICK, 10'd999);
    send_event(OP_TICK, 10'd1000);      // level wraps to zero
    send_event(OP_TICK, 10'd512);
    send_event(OP_INC, 10'd0);          // back to menu
  endtask

  task automatic test_clear_modes();
    inc_times(4);
    send_event(OP_CONFIRM, 10'd0);      // clear timer, blank screen
    send_event(OP_TICK, 10'd300);
    send_event(OP_INC, 10'd0);
    send_event(OP_CONFIRM, 10'd0);
    send_event(OP_INC, 10'd0);
    send_event(OP_CONFIRM, 10'd0);      // clear light
    send_event(OP_CONFIRM, 10'd0);
    send_event(OP_INC, 10'd0);          // index wraps to zero
  endtask

  task automatic test_random_sessions();
    int unsigned stop_at, pick, t_day, t_hour, t_min, t_now, r;
    logic [1:0] op;
    stop_at = events_sent + RandomEvents;
    while (events_sent < stop_at) begin
      steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // timer alarm one minute ahead of the clock
        enter_mode(3);
        t_now  = (ctl.hour * 60 + ctl.min + 1) % 1440;
        t_hour = t_now / 60;
        t_min  = t_now % 60;
        t_day  = (ctl.day < TimerPeriodDays) ? ctl.day : $urandom_range(0, 29);
        if ($urandom_range(0, 4) == 0) t_day = $urandom_range(0, 29);
        inc_times((t_day + TimerPeriodDays - ctl.a_day) % TimerPeriodDays);
        send_event(OP_CONFIRM, rand_sample());
        inc_times((t_hour + 24 - ctl.a_hour) % 24);
        send_event(OP_CONFIRM, rand_sample());
        inc_times((t_min + 60 - ctl.a_min) % 60);
        send_event(OP_CONFIRM, rand_sample());
        tick_run($urandom_range(55, 64));
        leave_alarm();
      end else if (pick < 40) begin
        // set the clock, often just before midnight
        enter_mode(2);
        send_event(OP_TICK, rand_sample());
        if ($urandom_range(0, 1)) begin
          t_hour = 23;
          t_min  = 59;
        end else begin
          t_hour = $urandom_range(0, 23);
          t_min  = $urandom_range(0, 59);
        end
        inc_times((t_hour + 24 - ctl.hour) % 24);
        send_event(OP_CONFIRM, rand_sample());
        inc_times((t_min + 60 - ctl.min) % 60);
        send_event(OP_CONFIRM, rand_sample());
        tick_run($urandom_range(1, 70));
        leave_alarm();
      end else if (pick < 60) begin
        // light window, then samples in and out of it
        enter_mode(4);
        inc_times($urandom_range(0, 10));
        send_event(OP_CONFIRM, rand_sample());
        inc_times($urandom_range(0, 10));
        send_event(OP_CONFIRM, rand_sample());
        tick_run($urandom_range(2, 12));
        leave_alarm();
      end else if (pick < 70) begin
        enter_mode($urandom_range(5, 6));
        if ($urandom_range(0, 1)) send_event(OP_TICK, rand_sample());
        if ($urandom_range(0, 2) == 0) send_event(OP_INC, rand_sample());
        send_event(OP_CONFIRM, rand_sample());
      end else if (pick < 80) begin
        enter_mode($urandom_range(0, 1));
        tick_run($urandom_range(1, 6));
        send_event($urandom_range(0, 1) ? OP_INC : OP_CONFIRM, rand_sample());
      end else begin
        // noise: any event code in any order
        repeat ($urandom_range(5, 20)) begin
          r = $urandom_range(0, 99);
          if (r < 40) op = OP_TICK;
          else if (r < 70) op = OP_INC;
          else if (r < 95) op = OP_CONFIRM;
          else op = OP_SPARE;
          send_event(op, rand_sample());
        end
      end
    end
    steady = 1'b0;
  endtask

  // ------------------------------------------------------------- receiver ---

  always @(negedge clk_i) begin : drain_side
    static int unsigned hold = 0;
    int unsigned n;
    if (hold != 0) begin
      hold--;
      m_axis_tready <= 1'b0;
    end else begin
      n = idle_len();
      if (n == 0) m_axis_tready <= 1'b1;
      else begin
        hold = n - 1;
        m_axis_tready <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : status_check
    status_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected transfer, expected none actual %h", $time, got);
      end else begin
        want = pending_status.pop_front();
        check_field("mode_now", want.mode, got.mode);
        check_field("alarm_active", want.alarm, got.alarm);
        check_field("seg_digit3", want.seg3, got.seg3);
        check_field("seg_digit2", want.seg2, got.seg2);
        check_field("seg_digit1", want.seg1, got.seg1);
        check_field("seg_digit0", want.seg0, got.seg0);
        check_field("led_pattern", want.leds, got.leds);
        check_field("menu_group_out", want.grp, got.grp);
        check_field("hour_out", want.hour, got.hour);
        check_field("minute_out", want.minute, got.minute);
        check_field("second_out", want.second, got.second);
        check_field("pad", want.pad, got.pad);
      end
    end
  end

  // ----------------------------------------------------------------- main ---

  initial begin : run
    ctl.mode       = MODE_SETCLOCK;
    ctl.menu_idx   = 0;
    ctl.grp        = GRP_SHOW;
    ctl.clk_sel    = 1'b0;
    ctl.tmr_sel    = TSEL_DAY;
    ctl.sec        = 0;
    ctl.min        = 0;
    ctl.hour       = 0;
    ctl.day        = 0;
    ctl.a_day      = 0;
    ctl.a_hour     = 0;
    ctl.a_min      = 0;
    ctl.level      = 0;
    ctl.upper      = 0;
    ctl.lower      = 0;
    ctl.edit_upper = 1'b0;
    ctl.tmr_armed  = 1'b0;
    ctl.lt_armed   = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_unused_op_at_reset();
    test_clock_set_entry();
    test_show_modes();
    test_clear_modes();
    test_random_sessions();

    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (errors == 0 && pending_status.size() == 0) begin
      $display("two_button_alarm_clock_controller_unit test passed");
    end else begin
      $display("two_button_alarm_clock_controller_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("two_button_alarm_clock_controller_unit test failed");
    $finish;
  end

endmodule
